[hw/rtl/tga_pkg.sv]
// Shared types and codes for the TGA run-length pixel decoder.
package tga_pkg;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic [14:0] image_width;
      logic [14:0] image_height;
      logic        end_of_image;
   } rsp_type;

   // compact event from the parser; the back end expands it into a result
   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] color;
      logic [7:0]  alpha_byte;
      logic        opaque;
      logic [7:0]  repeat_count;
      logic [14:0] image_width;
      logic [14:0] image_height;
      logic        end_of_image;
   } evt_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

[hw/rtl/tga_front.sv]
// Byte parser: header, ID skip, packet and pixel gathering; emits events.
module tga_front import tga_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req_data,
   output logic    evt_push,
   output evt_type evt_data
);

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_IDSKIP = 5'b00010,
      PH_PACKET = 5'b00100,
      PH_PIXEL  = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hidx_ff, hidx_in;
   logic [7:0]  id_skip_ff, id_skip_in;
   logic        comp_ff, comp_in;
   logic        has_alpha_ff, has_alpha_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [29:0] pix_left_ff, pix_left_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [1:0]  pbi_ff, pbi_in;
   logic [23:0] color_ff, color_in;
   logic        bad_ff, bad_in;

   phase_type   cur_phase;
   logic [4:0]  cur_hidx;
   logic        cur_bad;
   logic [7:0]  b;
   logic        no_pixels;
   logic [29:0] area;
   logic [7:0]  rep;
   logic [29:0] left_after;
   logic        emit;
   evt_type     evt;

   assign b = req_data.data_byte;
   assign no_pixels = width_ff[15] | height_ff[15] | (width_ff == 16'd0) | (height_ff == 16'd0);
   assign area = {15'd0, width_ff[14:0]} * {15'd0, height_ff[14:0]};

   always_comb begin
      cur_phase    = req_data.start_of_file ? PH_HEADER : phase_ff;
      cur_hidx     = req_data.start_of_file ? 5'd0 : hidx_ff;
      cur_bad      = req_data.start_of_file ? 1'b0 : bad_ff;
      phase_in     = cur_phase;
      hidx_in      = cur_hidx;
      bad_in       = cur_bad;
      id_skip_in   = id_skip_ff;
      comp_in      = comp_ff;
      has_alpha_in = has_alpha_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pix_left_in  = pix_left_ff;
      pkt_left_in  = pkt_left_ff;
      pkt_run_in   = pkt_run_ff;
      pbi_in       = pbi_ff;
      color_in     = color_ff;
      rep          = 8'd0;
      left_after   = pix_left_ff;
      emit         = 1'b0;
      evt          = '0;

      unique case (cur_phase)
         PH_HEADER: begin
            unique case (cur_hidx)
               5'd0:  id_skip_in = b;
               5'd1:  if (b != 8'd0) bad_in = 1'b1;
               5'd2: begin
                  if (b == 8'd10) comp_in = 1'b1;
                  else if (b == 8'd2) comp_in = 1'b0;
                  else bad_in = 1'b1;
               end
               5'd12: width_in[7:0]   = b;
               5'd13: width_in[15:8]  = b;
               5'd14: height_in[7:0]  = b;
               5'd15: height_in[15:8] = b;
               5'd16: begin
                  if (b == 8'd24) has_alpha_in = 1'b0;
                  else if (b == 8'd32) has_alpha_in = 1'b1;
                  else bad_in = 1'b1;
               end
               default: ;
            endcase
            hidx_in = cur_hidx + 5'd1;
            // last header byte: dimensions and format flags are already stored
            if (cur_hidx == 5'd17) begin
               hidx_in = 5'd0;
               emit    = 1'b1;
               if (cur_bad) begin
                  phase_in = PH_DONE;
                  evt.kind = KIND_ERROR;
               end else begin
                  pix_left_in        = no_pixels ? 30'd0 : area;
                  evt.kind           = KIND_HEADER;
                  evt.image_width    = width_ff[14:0];
                  evt.image_height   = height_ff[14:0];
                  evt.end_of_image   = no_pixels;
                  if (id_skip_ff != 8'd0) begin
                     phase_in = PH_IDSKIP;
                  end else begin
                     pkt_left_in = 8'd0;
                     pbi_in      = 2'd0;
                     if (no_pixels) phase_in = PH_DONE;
                     else phase_in = comp_ff ? PH_PACKET : PH_PIXEL;
                  end
               end
            end
         end
         PH_IDSKIP: begin
            if (id_skip_ff != 8'd0) id_skip_in = id_skip_ff - 8'd1;
            if (id_skip_in == 8'd0) begin
               pkt_left_in = 8'd0;
               pbi_in      = 2'd0;
               if (pix_left_ff == 30'd0) phase_in = PH_DONE;
               else phase_in = comp_ff ? PH_PACKET : PH_PIXEL;
            end
         end
         PH_PACKET: begin
            pkt_left_in = {1'b0, b[6:0]} + 8'd1;
            pkt_run_in  = b[7];
            pbi_in      = 2'd0;
            phase_in    = PH_PIXEL;
         end
         PH_PIXEL: begin
            if (pbi_ff != 2'd3) begin
               unique case (pbi_ff)
                  2'd0:    color_in[7:0]   = b;
                  2'd1:    color_in[15:8]  = b;
                  default: color_in[23:16] = b;
               endcase
               pbi_in = pbi_ff + 2'd1;
               emit   = (pbi_ff == 2'd2) && !has_alpha_ff;
            end else begin
               emit = 1'b1;
            end
            if (emit) begin
               pbi_in = 2'd0;
               if (comp_ff && pkt_run_ff) begin
                  // run longer than what is left of the image is clipped
                  if ({22'd0, pkt_left_ff} > pix_left_ff) rep = pix_left_ff[7:0];
                  else rep = pkt_left_ff;
                  pkt_left_in = 8'd0;
               end else begin
                  rep = 8'd1;
                  if (comp_ff && (pkt_left_ff != 8'd0)) pkt_left_in = pkt_left_ff - 8'd1;
               end
               left_after  = pix_left_ff - {22'd0, rep};
               pix_left_in = left_after;
               if (left_after == 30'd0) phase_in = PH_DONE;
               else if (comp_ff && (pkt_left_in == 8'd0)) phase_in = PH_PACKET;
               evt.kind         = KIND_PIXEL;
               evt.color        = color_in;
               evt.alpha_byte   = b;
               evt.opaque       = (pbi_ff != 2'd3);
               evt.repeat_count = rep;
               evt.end_of_image = (left_after == 30'd0);
            end
         end
         PH_DONE: ;
         default: ;
      endcase
   end

   assign evt_push = fire & emit;
   assign evt_data = evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hidx_ff      <= 5'd0;
         id_skip_ff   <= 8'd0;
         comp_ff      <= 1'b0;
         has_alpha_ff <= 1'b0;
         width_ff     <= 16'd0;
         height_ff    <= 16'd0;
         pix_left_ff  <= 30'd0;
         pkt_left_ff  <= 8'd0;
         pkt_run_ff   <= 1'b0;
         pbi_ff       <= 2'd0;
         color_ff     <= 24'd0;
         bad_ff       <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         id_skip_ff   <= id_skip_in;
         comp_ff      <= comp_in;
         has_alpha_ff <= has_alpha_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pix_left_ff  <= pix_left_in;
         pkt_left_ff  <= pkt_left_in;
         pkt_run_ff   <= pkt_run_in;
         pbi_ff       <= pbi_in;
         color_ff     <= color_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

[hw/rtl/tga_queue.sv]
// Two-entry event queue between the parser and the result stage.
module tga_queue import tga_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  evt_type      push_data,
   input  logic         pop,
   output evt_type      head_data,
   output q_status_type status
);

   evt_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign head_data        = slot_ff[rd_ptr_ff];
   assign status.full      = (count_ff == 2'd2);
   assign status.not_empty = (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

[hw/rtl/tga_back.sv]
// Result stage: expands queued events into result items, output register.
module tga_back import tga_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  evt_type      head_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign pop      = q_status.not_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_comb begin
      data_in      = '0;
      data_in.kind = head_data.kind;
      unique case (head_data.kind)
         KIND_PIXEL: begin
            data_in.red          = head_data.color[23:16];
            data_in.green        = head_data.color[15:8];
            data_in.blue         = head_data.color[7:0];
            data_in.alpha        = head_data.opaque ? OPAQUE_ALPHA : head_data.alpha_byte;
            data_in.repeat_count = head_data.repeat_count;
            data_in.end_of_image = head_data.end_of_image;
         end
         KIND_HEADER: begin
            data_in.image_width  = head_data.image_width;
            data_in.image_height = head_data.image_height;
            data_in.end_of_image = head_data.end_of_image;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[hw/rtl/tga_rle_pixel_decoder.sv]
// Top level of the TGA type 2/10 byte-stream pixel decoder.
//
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_stall  | req_type: data_byte, start_of_file
//  rsp_    | out       | rsp_valid/rsp_stall  | rsp_type: kind, RGBA, repeat, dims, end
//
// One byte per cycle is taken while req_stall is low; the parser updates
// its counters in the cycle a byte is accepted. Results are queued and then
// registered before rsp_. req_stall rises only when the two-entry queue is full.
// Reset is synchronous and leaves the parser expecting header byte zero.
module tga_rle_pixel_decoder import tga_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         fire;
   logic         evt_push;
   evt_type      evt_data;
   evt_type      head_data;
   logic         pop;

   assign req_stall = q_status.full;
   assign fire      = req_valid && !req_stall;

   tga_front u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_data (req_data),
      .evt_push (evt_push),
      .evt_data (evt_data)
   );

   tga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   tga_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !evt_push)
      else $error("event pushed into full queue");

   a_pixel_nonzero_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_PIXEL) |-> (rsp_data.repeat_count != 8'd0))
      else $error("pixel result with zero repeat");

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_ERROR) |->
         (rsp_data.repeat_count == 8'd0) && !rsp_data.end_of_image)
      else $error("error result carries pixel fields");

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped event not presented");

endmodule

[dv/tga_tb_pkg.sv]
// TGA file format constants used by the decoder testbench.
package tga_tb_pkg;

   localparam int TGA_HEADER_LEN = 18;

   // header byte offsets
   localparam int HDR_ID_LEN      = 0;
   localparam int HDR_CMAP_TYPE   = 1;
   localparam int HDR_IMAGE_TYPE  = 2;
   localparam int HDR_WIDTH_LO    = 12;
   localparam int HDR_WIDTH_HI    = 13;
   localparam int HDR_HEIGHT_LO   = 14;
   localparam int HDR_HEIGHT_HI   = 15;
   localparam int HDR_PIXEL_DEPTH = 16;

   localparam logic [7:0] TGA_TYPE_TRUECOLOR     = 8'd2;
   localparam logic [7:0] TGA_TYPE_RLE_TRUECOLOR = 8'd10;
   localparam logic [7:0] TGA_BPP_24             = 8'd24;
   localparam logic [7:0] TGA_BPP_32             = 8'd32;

   localparam logic [7:0] RLE_RUN_FLAG   = 8'h80;
   localparam logic [7:0] RLE_COUNT_MASK = 8'h7f;

endpackage

[dv/tga_stream_checker.sv]
// Watches both decoder channels, predicts every result from the bytes taken and compares.
module tga_stream_checker import tga_pkg::*; import tga_tb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      results_owed
);

   typedef enum logic [2:0] {
      ST_HEADER,
      ST_ID_SKIP,
      ST_PACKET,
      ST_PIXEL,
      ST_DONE
   } stage_type;

   stage_type   stage;
   int          hdr_index;
   logic [7:0]  id_left;
   bit          compressed;
   bit          alpha_present;
   bit          hdr_invalid;
   bit          run_packet;
   logic [15:0] width_v;
   logic [15:0] height_v;
   logic [29:0] px_remaining;
   logic [7:0]  pkt_remaining;
   int          byte_slot;
   logic [23:0] rgb_acc;

   rsp_type     decoded_q[$];
   rsp_type     predicted;
   rsp_type     oldest;
   bit          produced;

   task automatic clear_decoder();
      stage         = ST_HEADER;
      hdr_index     = 0;
      id_left       = '0;
      compressed    = 0;
      alpha_present = 0;
      hdr_invalid   = 0;
      run_packet    = 0;
      width_v       = '0;
      height_v      = '0;
      px_remaining  = '0;
      pkt_remaining = '0;
      byte_slot     = 0;
      rgb_acc       = '0;
   endtask

   task automatic enter_pixel_data();
      pkt_remaining = '0;
      byte_slot     = 0;
      if (px_remaining == 0) begin
         stage = ST_DONE;
      end else begin
         stage = compressed ? ST_PACKET : ST_PIXEL;
      end
   endtask

   task automatic decode_byte(input req_type item, output bit got_one, output rsp_type res);
      logic [7:0]  b;
      logic [7:0]  alpha_v;
      logic [29:0] rep;
      bit          ready;
      b       = item.data_byte;
      got_one = 0;
      res     = '0;
      alpha_v = '0;
      ready   = 0;
      if (item.start_of_file) begin
         stage       = ST_HEADER;
         hdr_index   = 0;
         hdr_invalid = 0;
      end
      case (stage)
         ST_HEADER: begin
            case (hdr_index)
               HDR_ID_LEN:    id_left = b;
               HDR_CMAP_TYPE: if (b != 0) hdr_invalid = 1;
               HDR_IMAGE_TYPE: begin
                  if (b == TGA_TYPE_RLE_TRUECOLOR) compressed = 1;
                  else if (b == TGA_TYPE_TRUECOLOR) compressed = 0;
                  else hdr_invalid = 1;
               end
               HDR_WIDTH_LO:  width_v[7:0]   = b;
               HDR_WIDTH_HI:  width_v[15:8]  = b;
               HDR_HEIGHT_LO: height_v[7:0]  = b;
               HDR_HEIGHT_HI: height_v[15:8] = b;
               HDR_PIXEL_DEPTH: begin
                  if (b == TGA_BPP_24) alpha_present = 0;
                  else if (b == TGA_BPP_32) alpha_present = 1;
                  else hdr_invalid = 1;
               end
               default: ;
            endcase
            hdr_index++;
            if (hdr_index == TGA_HEADER_LEN) begin
               hdr_index = 0;
               got_one   = 1;
               if (hdr_invalid) begin
                  stage    = ST_DONE;
                  res.kind = KIND_ERROR;
               end else begin
                  // a dimension with the sign bit set counts as an empty image
                  if (width_v[15] || height_v[15]) begin
                     px_remaining = '0;
                  end else begin
                     px_remaining = 30'(width_v[14:0]) * 30'(height_v[14:0]);
                  end
                  if (id_left != 0) stage = ST_ID_SKIP;
                  else enter_pixel_data();
                  res.kind         = KIND_HEADER;
                  res.image_width  = width_v[14:0];
                  res.image_height = height_v[14:0];
                  res.end_of_image = (px_remaining == 0);
               end
            end
         end
         ST_ID_SKIP: begin
            if (id_left != 0) id_left--;
            if (id_left == 0) enter_pixel_data();
         end
         ST_PACKET: begin
            pkt_remaining = {1'b0, b[6:0]} + 8'd1;
            run_packet    = b[7];
            byte_slot     = 0;
            stage         = ST_PIXEL;
         end
         ST_PIXEL: begin
            // bytes come blue, green, red, then alpha for 32-bit pixels
            if (byte_slot < 3) begin
               rgb_acc[8*byte_slot +: 8] = b;
               byte_slot++;
               if (byte_slot == 3 && !alpha_present) begin
                  alpha_v = OPAQUE_ALPHA;
                  ready   = 1;
               end
            end else begin
               alpha_v = b;
               ready   = 1;
            end
            if (ready) begin
               byte_slot = 0;
               if (compressed && run_packet) begin
                  rep = 30'(pkt_remaining);
                  if (rep > px_remaining) rep = px_remaining;
                  pkt_remaining = '0;
               end else begin
                  rep = 30'd1;
                  if (compressed && pkt_remaining != 0) pkt_remaining--;
               end
               px_remaining -= rep;
               if (px_remaining == 0) stage = ST_DONE;
               else if (compressed && pkt_remaining == 0) stage = ST_PACKET;
               got_one          = 1;
               res.kind         = KIND_PIXEL;
               res.red          = rgb_acc[23:16];
               res.green        = rgb_acc[15:8];
               res.blue         = rgb_acc[7:0];
               res.alpha        = alpha_v;
               res.repeat_count = rep[7:0];
               res.end_of_image = (px_remaining == 0);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         decoded_q.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("result with none expected: kind %0d", rsp_data.kind);
               error_count++;
            end else begin
               oldest = decoded_q.pop_front();
               check_field("kind", oldest.kind, rsp_data.kind);
               check_field("red", oldest.red, rsp_data.red);
               check_field("green", oldest.green, rsp_data.green);
               check_field("blue", oldest.blue, rsp_data.blue);
               check_field("alpha", oldest.alpha, rsp_data.alpha);
               check_field("repeat_count", oldest.repeat_count, rsp_data.repeat_count);
               check_field("image_width", oldest.image_width, rsp_data.image_width);
               check_field("image_height", oldest.image_height, rsp_data.image_height);
               check_field("end_of_image", oldest.end_of_image, rsp_data.end_of_image);
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data, produced, predicted);
            if (produced) decoded_q.push_back(predicted);
         end
      end
      results_owed <= decoded_q.size();
   end

endmodule

[dv/tb_top.sv]
// Top of the TGA decoder testbench: clock, reset, file byte streams and the verdict.
module tb_top;
   import tga_pkg::*;
   import tga_tb_pkg::*;

   localparam int         NO_CUT       = 1 << 30;
   localparam int         HOLD_CYCLES  = 60;
   localparam int         BYTES_PER_BURST = 240;
   localparam logic [7:0] CMAP_PRESENT = 8'd1;
   localparam logic [7:0] TYPE_GRAY    = 8'd3;
   localparam logic [7:0] BPP_16       = 8'd16;

   logic    clock     = 0;
   logic    reset     = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   int error_count;
   int results_owed;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;
   int bytes_sent  = 0;
   int idle_by_burst[4]  = '{0, 77, 0, 23};
   int stall_by_burst[4] = '{0, 0, 77, 23};
   int target;

   always #5 clock = ~clock;

   tga_rle_pixel_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   tga_stream_checker result_watch (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done <= holds_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   task automatic send_item(input logic [7:0] value, input logic sof);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{data_byte: value, start_of_file: sof};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file(input logic [7:0] itype, input logic [7:0] bpp,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] id_len, input logic [7:0] cmap,
                            input bit sof_first, input int max_bytes, input int trailing);
      logic [7:0] bytes_q[$];
      longint     remaining;
      int         n;
      int         chunk;
      int         px_len;
      bit         supported;
      bytes_q = {id_len, cmap, itype};
      repeat (9) bytes_q.push_back(rand_byte());
      bytes_q.push_back(w[7:0]);
      bytes_q.push_back(w[15:8]);
      bytes_q.push_back(h[7:0]);
      bytes_q.push_back(h[15:8]);
      bytes_q.push_back(bpp);
      bytes_q.push_back(rand_byte());
      repeat (id_len) bytes_q.push_back(rand_byte());
      supported = (cmap == 0) &&
                  (itype == TGA_TYPE_TRUECOLOR || itype == TGA_TYPE_RLE_TRUECOLOR) &&
                  (bpp == TGA_BPP_24 || bpp == TGA_BPP_32);
      px_len    = (bpp == TGA_BPP_32) ? 4 : 3;
      remaining = (!supported || w[15] || h[15]) ? 0 : longint'(w) * longint'(h);
      while (remaining > 0 && bytes_q.size() < max_bytes) begin
         if (itype == TGA_TYPE_RLE_TRUECOLOR) begin
            // big images get long runs so they stay cheap
            if (remaining > 64 || $urandom_range(3) == 0) n = $urandom_range(1, 128);
            else n = $urandom_range(1, 8);
            chunk = (n < remaining) ? n : int'(remaining);
            if (remaining > 64 || $urandom_range(1)) begin
               bytes_q.push_back(RLE_RUN_FLAG | 8'(n - 1));
               repeat (px_len) bytes_q.push_back(rand_byte());
            end else begin
               bytes_q.push_back(8'(n - 1));
               repeat (chunk * px_len) bytes_q.push_back(rand_byte());
            end
            remaining -= chunk;
         end else begin
            repeat (px_len) bytes_q.push_back(rand_byte());
            remaining--;
         end
      end
      repeat (trailing) bytes_q.push_back(rand_byte());
      foreach (bytes_q[i]) begin
         if (i < max_bytes) send_item(bytes_q[i], sof_first && (i == 0));
      end
   endtask

   task automatic send_random_file();
      logic [7:0]  itype;
      logic [7:0]  bpp;
      logic [7:0]  cmap;
      logic [7:0]  id_len;
      logic [15:0] w;
      logic [15:0] h;
      int          r;
      int          max_bytes;
      int          trailing;
      bit          sof_first;
      r     = $urandom_range(99);
      itype = (r < 50) ? TGA_TYPE_RLE_TRUECOLOR : (r < 88) ? TGA_TYPE_TRUECOLOR : rand_byte();
      bpp   = ($urandom_range(9) == 0) ? rand_byte() :
              ($urandom_range(1) ? TGA_BPP_32 : TGA_BPP_24);
      cmap  = ($urandom_range(19) == 0) ? rand_byte() : 8'd0;
      r     = $urandom_range(99);
      id_len = (r < 70) ? 8'd0 : (r < 98) ? 8'($urandom_range(1, 4)) : rand_byte();
      max_bytes = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : NO_CUT;
      w = 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 6));
      r = $urandom_range(99);
      if (r < 10) begin
         w     = 16'($urandom_range(8, 24));
         h     = 16'($urandom_range(8, 24));
         itype = TGA_TYPE_RLE_TRUECOLOR;
      end else if (r < 15) begin
         if ($urandom_range(1)) w = '0;
         else h = '0;
      end else if (r < 20) begin
         if ($urandom_range(1)) w = 16'($urandom_range(65535)) | 16'h8000;
         else h = 16'($urandom_range(65535)) | 16'h8000;
      end else if (r < 24) begin
         w         = 16'($urandom_range(65535));
         h         = 16'($urandom_range(65535));
         max_bytes = $urandom_range(TGA_HEADER_LEN, 60);
      end
      sof_first = ($urandom_range(19) != 0);
      trailing  = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
      send_file(itype, bpp, w, h, id_len, cmap, sof_first, max_bytes, trailing);
   endtask

   task automatic wait_for_results();
      req_valid <= 0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;

      // first file after reset carries no start flag
      send_file(TGA_TYPE_TRUECOLOR, TGA_BPP_24, 1, 1, 0, 0, 0, NO_CUT, 0);
      send_file(TGA_TYPE_TRUECOLOR, TGA_BPP_32, 2, 2, 2, 0, 1, NO_CUT, 2);
      send_file(TGA_TYPE_RLE_TRUECOLOR, TGA_BPP_24, 3, 3, 0, 0, 1, NO_CUT, 0);
      send_file(TGA_TYPE_RLE_TRUECOLOR, TGA_BPP_32, 1, 1, 8'd255, 0, 1, NO_CUT, 0);
      // full-length run packet on a 3-pixel image gets clipped
      send_file(TGA_TYPE_RLE_TRUECOLOR, TGA_BPP_32, 3, 1, 0, 0, 1, TGA_HEADER_LEN, 0);
      send_item(RLE_RUN_FLAG | RLE_COUNT_MASK, 0);
      send_item(8'hff, 0);
      send_item(8'h00, 0);
      send_item(8'hff, 0);
      send_item(8'h00, 0);
      send_item(rand_byte(), 0);
      // empty images (zero size, sign bit set), then a maximum-size image cut short
      send_file(TGA_TYPE_TRUECOLOR, TGA_BPP_24, 0, 5, 3, 0, 1, NO_CUT, 2);
      send_file(TGA_TYPE_RLE_TRUECOLOR, TGA_BPP_24, 16'h8003, 2, 0, 0, 1, NO_CUT, 2);
      send_file(TGA_TYPE_RLE_TRUECOLOR, TGA_BPP_24, 16'h7fff, 16'h7fff, 0, 0, 1, 40, 0);
      // unsupported formats
      send_file(TGA_TYPE_TRUECOLOR, TGA_BPP_24, 2, 2, 0, CMAP_PRESENT, 1, NO_CUT, 3);
      send_file(TYPE_GRAY, TGA_BPP_24, 2, 2, 0, 0, 1, NO_CUT, 3);
      send_file(TGA_TYPE_TRUECOLOR, BPP_16, 2, 2, 0, 0, 1, NO_CUT, 3);
      // abandon a file partway and start another
      send_file(TGA_TYPE_TRUECOLOR, TGA_BPP_24, 4, 4, 0, 0, 1, 25, 0);
      send_file(TGA_TYPE_RLE_TRUECOLOR, TGA_BPP_32, 2, 3, 1, 0, 1, NO_CUT, 0);
      wait_for_results();

      for (int burst = 0; burst < 4; burst++) begin
         idle_pct   = idle_by_burst[burst];
         stall_pct <= stall_by_burst[burst];
         // long receiver hold-off while bytes keep coming
         if (burst == 0) holds_asked <= holds_asked + 1;
         target = bytes_sent + BYTES_PER_BURST;
         while (bytes_sent < target) send_random_file();
         wait_for_results();
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("** tga_rle_pixel_decoder: PASSED **");
      end else begin
         $display("** tga_rle_pixel_decoder: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** tga_rle_pixel_decoder: FAILED **");
      $finish;
   end

endmodule
